// ===== hdl/energy_pulse_meter_assert.svh =====
// Assertion macros for the energy pulse meter checker.
// Both macros expect signals named clk and rst_n in the scope where they are used.
`ifndef ENERGY_PULSE_METER_ASSERT_SVH
`define ENERGY_PULSE_METER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/epm_pkg.sv =====
// Shared types and constants for the energy pulse meter.
// No dependencies; used by every module of the block.
package epm_pkg;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_PULSE = 1'b1;

  localparam logic [15:0] IDLE_TIMEOUT_RST  = 16'd3000;
  localparam logic [15:0] PERIOD_MS_RST     = 16'd5000;
  localparam logic [7:0]  PERIODS_PER_RPT_RST = 8'd12;

  localparam logic [16:0] IDLE_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    EV_LOAD_REMOVED = 2'd0,
    EV_PERIOD_COUNT = 2'd1,
    EV_REPORT_TOTAL = 2'd2
  } epm_event_t;

  typedef enum logic [1:0] {
    REG_IDLE_TIMEOUT      = 2'd0,
    REG_PERIOD_MS         = 2'd1,
    REG_PERIODS_PER_REPORT = 2'd2
  } epm_reg_t;

  // Windows reported with the results of one tick.
  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [15:0] period_ms;
    logic [23:0] report_ms;
  } epm_win_t;

  // Hand-off from the state update to the result drain.
  typedef struct packed {
    logic     load;
    logic     period_fire;
    logic     report_fire;
    epm_win_t win;
  } epm_snap_t;

endpackage

// ===== hdl/epm_update.sv =====
// Input word register and the per-channel counter state of the pulse meter.
// Depends on epm_pkg; hands each tick's results to epm_drain.
module epm_update import epm_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_req_type,
  input  logic [2:0]                 in_channel,
  input  logic [15:0]                idle_timeout_ms,
  input  logic [15:0]                period_ms,
  input  logic [7:0]                 periods_per_report,
  input  logic                       drain_busy,
  output epm_snap_t                  snap,
  output logic [CHANNELS-1:0]        lr_mask,
  output logic [CHANNELS-1:0][31:0]  per_val,
  output logic [CHANNELS-1:0][31:0]  rep_val
);

  logic        in_vld_r, in_vld_nxt;
  logic        req_r;
  logic [2:0]  ch_r;
  logic        go;
  logic        accept;

  logic [CHANNELS-1:0][16:0] idle_r, idle_nxt;
  logic [CHANNELS-1:0][31:0] pulses_r, pulses_nxt;
  logic [CHANNELS-1:0][31:0] total_r, total_nxt;
  logic [15:0] ptimer_r, ptimer_nxt;
  logic [7:0]  pidx_r, pidx_nxt;

  logic [15:0] ptimer_inc;
  logic [7:0]  pidx_inc;
  logic        pfire;
  logic        rfire;
  logic [23:0] report_ms;

  // A pulse never produces results, so it may be applied while a tick drains.
  assign go       = in_vld_r & ((req_r == REQ_PULSE) | ~drain_busy);
  assign in_stall = in_vld_r & ~go;
  assign accept   = in_valid & ~in_stall;
  assign in_vld_nxt = accept | (in_vld_r & ~go);

  assign ptimer_inc = (ptimer_r == 16'hFFFF) ? ptimer_r : ptimer_r + 16'd1;
  assign pfire      = (ptimer_inc >= period_ms);
  assign pidx_inc   = (pfire && pidx_r != 8'hFF) ? pidx_r + 8'd1 : pidx_r;
  assign rfire      = (pidx_inc >= periods_per_report);
  assign report_ms  = 24'(period_ms) * 24'(periods_per_report);

  always_comb begin
    logic [16:0] idle_inc;
    logic [32:0] sum;
    logic [31:0] total_after;
    idle_inc    = '0;
    sum         = '0;
    total_after = '0;
    idle_nxt    = idle_r;
    pulses_nxt  = pulses_r;
    total_nxt   = total_r;
    ptimer_nxt  = ptimer_r;
    pidx_nxt    = pidx_r;
    lr_mask     = '0;
    per_val     = pulses_r;
    rep_val     = total_r;
    for (int c = 0; c < CHANNELS; c++) begin
      idle_inc    = (idle_r[c] == IDLE_MAX) ? idle_r[c] : idle_r[c] + 17'd1;
      lr_mask[c]  = (idle_inc > {1'b0, idle_timeout_ms});
      sum         = {1'b0, total_r[c]} + {1'b0, pulses_r[c]};
      total_after = pfire ? (sum[32] ? 32'hFFFF_FFFF : sum[31:0]) : total_r[c];
      rep_val[c]  = total_after;
      if (req_r == REQ_PULSE) begin
        if (ch_r == 3'(c)) begin
          idle_nxt[c]   = '0;
          pulses_nxt[c] = (pulses_r[c] == 32'hFFFF_FFFF) ? pulses_r[c]
                                                          : pulses_r[c] + 32'd1;
        end
      end else begin
        idle_nxt[c]   = lr_mask[c] ? 17'd0 : idle_inc;
        pulses_nxt[c] = pfire ? 32'd0 : pulses_r[c];
        total_nxt[c]  = rfire ? 32'd0 : total_after;
      end
    end
    if (req_r == REQ_TICK) begin
      ptimer_nxt = pfire ? 16'd0 : ptimer_inc;
      pidx_nxt   = rfire ? 8'd0 : pidx_inc;
    end
  end

  always_comb begin
    snap.load           = go & (req_r == REQ_TICK);
    snap.period_fire    = pfire;
    snap.report_fire    = rfire;
    snap.win.timeout_ms = idle_timeout_ms;
    snap.win.period_ms  = period_ms;
    snap.win.report_ms  = report_ms;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      idle_r   <= '0;
      pulses_r <= '0;
      total_r  <= '0;
      ptimer_r <= '0;
      pidx_r   <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (go) begin
        idle_r   <= idle_nxt;
        pulses_r <= pulses_nxt;
        total_r  <= total_nxt;
        ptimer_r <= ptimer_nxt;
        pidx_r   <= pidx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      ch_r  <= in_channel;
    end
  end

endmodule

// ===== hdl/epm_drain.sv =====
// Holds one tick's results and sends one word per cycle while not stalled.
// Depends on epm_pkg; fed by epm_update.
module epm_drain import epm_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  epm_snap_t                  snap,
  input  logic [CHANNELS-1:0]        lr_mask,
  input  logic [CHANNELS-1:0][31:0]  per_val,
  input  logic [CHANNELS-1:0][31:0]  rep_val,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_channel_out,
  output logic [1:0]                 out_event_kind,
  output logic [23:0]                out_window_ms,
  output logic [31:0]                out_pulse_value,
  output logic                       out_last_of_run
);

  localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NRES = 3 * CHANNELS;

  // Pending bits: load removed per channel, then period counts, then totals.
  logic [NRES-1:0]           pend_r, pend_nxt;
  logic [CHANNELS-1:0][31:0] per_val_r;
  logic [CHANNELS-1:0][31:0] rep_val_r;
  epm_win_t                  win_r;

  logic                      out_vld_r;
  logic [2:0]                ch_out_r;
  logic [1:0]                kind_r;
  logic [23:0]               win_out_r;
  logic [31:0]               val_r;
  logic                      last_r;

  logic [NRES-1:0]           sel_bit;
  epm_event_t                sel_kind;
  logic [CHW-1:0]            sel_ch;
  logic [31:0]               sel_val;
  logic [23:0]               sel_win;
  logic                      load_out;

  assign busy     = |pend_r;
  assign load_out = busy & (~out_vld_r | ~out_stall);

  // The loop runs from the back so the lowest pending bit wins.
  always_comb begin
    sel_bit  = '0;
    sel_kind = EV_LOAD_REMOVED;
    sel_ch   = '0;
    sel_val  = '0;
    for (int k = 2; k >= 0; k--) begin
      for (int c = CHANNELS - 1; c >= 0; c--) begin
        if (pend_r[k*CHANNELS + c]) begin
          sel_bit                = '0;
          sel_bit[k*CHANNELS + c] = 1'b1;
          sel_kind               = epm_event_t'(2'(k));
          sel_ch                 = CHW'(c);
          sel_val                = (k == 1) ? per_val_r[c] :
                                   (k == 2) ? rep_val_r[c] : 32'd0;
        end
      end
    end
  end

  always_comb begin
    unique case (sel_kind)
      EV_LOAD_REMOVED: sel_win = {8'd0, win_r.timeout_ms};
      EV_PERIOD_COUNT: sel_win = {8'd0, win_r.period_ms};
      EV_REPORT_TOTAL: sel_win = win_r.report_ms;
      default:         sel_win = '0;
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    if (snap.load) begin
      pend_nxt = {{CHANNELS{snap.report_fire}}, {CHANNELS{snap.period_fire}}, lr_mask};
    end else if (load_out) begin
      pend_nxt = pend_r & ~sel_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap.load) begin
      per_val_r <= per_val;
      rep_val_r <= rep_val;
      win_r     <= snap.win;
    end
    if (load_out) begin
      ch_out_r  <= 3'(sel_ch);
      kind_r    <= sel_kind;
      win_out_r <= sel_win;
      val_r     <= sel_val;
      last_r    <= ((pend_r & ~sel_bit) == '0);
    end
  end

  assign out_valid       = out_vld_r;
  assign out_channel_out = ch_out_r;
  assign out_event_kind  = kind_r;
  assign out_window_ms   = win_out_r;
  assign out_pulse_value = val_r;
  assign out_last_of_run = last_r;

endmodule

// ===== hdl/energy_pulse_meter.sv =====
// Energy pulse meter top level: configuration registers, state update and result drain.
// Depends on epm_pkg, epm_update and epm_drain.
//
// Every input word is held in the input register and then applied to the channel
// counters, so a pulse word can be taken every cycle unless a tick waits in the
// input register. A tick word also captures its results (up to three per
// channel: load removed, period count, report total) into a holding stage that
// feeds the output register one result per cycle while the output is not
// stalled. A following tick waits in the input register until the previous
// tick's last result has moved into the output register; pulses ahead of it
// are applied meanwhile.
module energy_pulse_meter import epm_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [2:0]  in_channel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_channel_out,
  output logic [1:0]  out_event_kind,
  output logic [23:0] out_window_ms,
  output logic [31:0] out_pulse_value,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] idle_timeout_r;
  logic [15:0] period_ms_r;
  logic [7:0]  ppr_r;
  logic        cfg_wr;
  epm_reg_t    reg_sel;

  epm_snap_t                 snap;
  logic [CHANNELS-1:0]       lr_mask;
  logic [CHANNELS-1:0][31:0] per_val;
  logic [CHANNELS-1:0][31:0] rep_val;
  logic                      drain_busy;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = epm_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= IDLE_TIMEOUT_RST;
      period_ms_r    <= PERIOD_MS_RST;
      ppr_r          <= PERIODS_PER_RPT_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_IDLE_TIMEOUT:       idle_timeout_r <= pwdata[15:0];
        REG_PERIOD_MS:          period_ms_r    <= pwdata[15:0];
        REG_PERIODS_PER_REPORT: ppr_r          <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_IDLE_TIMEOUT:       prdata = {16'd0, idle_timeout_r};
      REG_PERIOD_MS:          prdata = {16'd0, period_ms_r};
      REG_PERIODS_PER_REPORT: prdata = {24'd0, ppr_r};
      default:                prdata = '0;
    endcase
  end

  epm_update #(
    .CHANNELS(CHANNELS)
  ) u_update (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_channel        (in_channel),
    .idle_timeout_ms   (idle_timeout_r),
    .period_ms         (period_ms_r),
    .periods_per_report(ppr_r),
    .drain_busy        (drain_busy),
    .snap              (snap),
    .lr_mask           (lr_mask),
    .per_val           (per_val),
    .rep_val           (rep_val)
  );

  epm_drain #(
    .CHANNELS(CHANNELS)
  ) u_drain (
    .clk            (clk),
    .rst_n          (rst_n),
    .snap           (snap),
    .lr_mask        (lr_mask),
    .per_val        (per_val),
    .rep_val        (rep_val),
    .busy           (drain_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel_out(out_channel_out),
    .out_event_kind (out_event_kind),
    .out_window_ms  (out_window_ms),
    .out_pulse_value(out_pulse_value),
    .out_last_of_run(out_last_of_run)
  );

endmodule

// ===== hdl/epm_checker.sv =====
// Port-level checks for the energy pulse meter, bound to the top level.
// Depends on epm_pkg and energy_pulse_meter_assert.svh.
`include "energy_pulse_meter_assert.svh"

module epm_port_checker import epm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_channel_out,
  input logic [1:0]  out_event_kind,
  input logic [23:0] out_window_ms,
  input logic [31:0] out_pulse_value,
  input logic        out_last_of_run
);

  logic [61:0] out_word;
  logic        out_held;
  logic        lr_word;
  logic        period_word;
  logic        run_moves;
  logic        short_window;
  logic        lr_ok;

  assign out_word     = {out_channel_out, out_event_kind, out_window_ms, out_pulse_value,
                         out_last_of_run};
  assign out_held     = out_valid && out_stall;
  assign lr_word      = out_valid && (out_event_kind == EV_LOAD_REMOVED);
  assign period_word  = out_valid && (out_event_kind == EV_PERIOD_COUNT);
  assign run_moves    = out_valid && !out_stall && !out_last_of_run;
  assign short_window = (out_window_ms[23:16] == 8'd0);
  assign lr_ok        = (out_pulse_value == 32'd0) && short_window;

  // A stalled result word keeps its contents.
  `EPM_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "stalled word changed")

  // A load-removed word carries no count and the 16-bit timeout as its window.
  `EPM_ASSERT_NOW(a_lr_payload, lr_word, lr_ok, "bad load-removed word")

  // A period word reports the 16-bit period length.
  `EPM_ASSERT_NOW(a_period_window, period_word, short_window, "period window out of range")

  // Results of one tick follow each other without a gap.
  `EPM_ASSERT_NEXT(a_run_gapless, run_moves, out_valid, "gap inside a tick's results")

endmodule

bind energy_pulse_meter epm_port_checker u_epm_checker (.*);
